/* design/assert_macros.svh */
// Assertion macros used by the checker file of the stick calibration block.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SDC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SDC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/sdc_pkg.sv */
// Package of the stick calibration block: word types, register indexes and
// pipeline constants. Used by every module of the block but sdc_div_pipe; depends on nothing.
package sdc_pkg;

	localparam int RAW_W = 16;
	localparam int CFG_W = 17;
	localparam int DZ_W  = 16;

	localparam int DEF_OUT_MIN = -32768;
	localparam int DEF_OUT_MAX = 32767;

	// Register indexes of the configuration port.
	localparam logic [2:0] REG_X_LOW  = 3'd0;
	localparam logic [2:0] REG_X_MID  = 3'd1;
	localparam logic [2:0] REG_X_HIGH = 3'd2;
	localparam logic [2:0] REG_Y_LOW  = 3'd3;
	localparam logic [2:0] REG_Y_MID  = 3'd4;
	localparam logic [2:0] REG_Y_HIGH = 3'd5;
	localparam logic [2:0] REG_DEAD   = 3'd6;
	localparam logic [2:0] REG_MODE   = 3'd7;

	// Calibration modes; the top mode code behaves as the radial one.
	localparam logic [1:0] MODE_BYPASS = 2'd0;
	localparam logic [1:0] MODE_CAL    = 2'd1;
	localparam logic [1:0] MODE_RADIAL = 2'd2;

	// Pipeline depths.
	localparam int QUO_W    = 16;
	localparam int MAG_W    = 32;
	localparam int LANE_LAT = 4 + QUO_W;
	localparam int RAD_LAT  = 4 + MAG_W + QUO_W;
	localparam int PIPE_LAT = LANE_LAT + RAD_LAT;

	typedef struct packed {
		logic signed [RAW_W-1:0] raw_x;
		logic signed [RAW_W-1:0] raw_y;
	} in_t;

	typedef struct packed {
		logic signed [RAW_W-1:0] out_x;
		logic signed [RAW_W-1:0] out_y;
	} out_t;

	typedef struct packed {
		logic signed [CFG_W-1:0] lo;
		logic signed [CFG_W-1:0] mid;
		logic signed [CFG_W-1:0] hi;
		logic [DZ_W-1:0]         dz;
		logic                    bypass;
	} axis_cfg_t;

endpackage

/* design/sdc_div_pipe.sv */
// Pipelined restoring divider, one quotient bit per stage, with a sideband word.
// Needs sdc_pkg only through its callers; the numerator must give a quotient
// that fits in QW bits.
module sdc_div_pipe #(
	parameter int DW = 17,
	parameter int QW = 16,
	parameter int SW = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [QW+DW-1:0] num,
	input  logic [DW-1:0]    den,
	input  logic [SW-1:0]    side_in,
	output logic             out_valid,
	output logic [QW-1:0]    quo,
	output logic [SW-1:0]    side_out
);

	logic          vld_s  [QW];
	logic [DW-1:0] rem_s  [QW];
	logic [QW-1:0] low_s  [QW];
	logic [DW-1:0] den_s  [QW];
	logic [QW-1:0] quo_s  [QW];
	logic [SW-1:0] side_s [QW];

	for (genvar k = 0; k < QW; k++) begin : g_stg
		logic          p_vld;
		logic [DW-1:0] p_rem;
		logic [QW-1:0] p_low;
		logic [DW-1:0] p_den;
		logic [QW-1:0] p_quo;
		logic [SW-1:0] p_side;
		logic [DW:0]   trial;
		logic          ge;

		if (k == 0) begin : g_first
			assign p_vld  = in_valid;
			assign p_rem  = num[QW+DW-1:QW];
			assign p_low  = num[QW-1:0];
			assign p_den  = den;
			assign p_quo  = '0;
			assign p_side = side_in;
		end else begin : g_next
			assign p_vld  = vld_s[k-1];
			assign p_rem  = rem_s[k-1];
			assign p_low  = low_s[k-1];
			assign p_den  = den_s[k-1];
			assign p_quo  = quo_s[k-1];
			assign p_side = side_s[k-1];
		end

		assign trial = {p_rem, p_low[QW-1]};
		assign ge    = trial >= {1'b0, p_den};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= p_vld;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k]  <= ge ? DW'(trial - {1'b0, p_den}) : DW'(trial);
			low_s[k]  <= {p_low[QW-2:0], 1'b0};
			den_s[k]  <= p_den;
			quo_s[k]  <= {p_quo[QW-2:0], ge};
			side_s[k] <= p_side;
		end
	end

	assign out_valid = vld_s[QW-1];
	assign quo       = quo_s[QW-1];
	assign side_out  = side_s[QW-1];

endmodule

/* design/sdc_isqrt.sv */
// Pipelined digit-by-digit square root of mag * 2^32, one root bit per stage.
// Depends on sdc_pkg for the operand width.
module sdc_isqrt import sdc_pkg::*; #(
	parameter int SW = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [MAG_W-1:0] mag,
	input  logic [SW-1:0]    side_in,
	output logic             out_valid,
	output logic [MAG_W-1:0] root,
	output logic [SW-1:0]    side_out
);

	localparam int RW = MAG_W + 1;

	logic             vld_s  [MAG_W];
	logic [RW-1:0]    rem_s  [MAG_W];
	logic [MAG_W-1:0] src_s  [MAG_W];
	logic [MAG_W-1:0] root_s [MAG_W];
	logic [SW-1:0]    side_s [MAG_W];

	for (genvar k = 0; k < MAG_W; k++) begin : g_stg
		logic             p_vld;
		logic [RW-1:0]    p_rem;
		logic [MAG_W-1:0] p_src;
		logic [MAG_W-1:0] p_root;
		logic [SW-1:0]    p_side;
		logic [RW+1:0]    sh;
		logic [RW+1:0]    trial;
		logic             ge;

		if (k == 0) begin : g_first
			assign p_vld  = in_valid;
			assign p_rem  = '0;
			assign p_src  = mag;
			assign p_root = '0;
			assign p_side = side_in;
		end else begin : g_next
			assign p_vld  = vld_s[k-1];
			assign p_rem  = rem_s[k-1];
			assign p_src  = src_s[k-1];
			assign p_root = root_s[k-1];
			assign p_side = side_s[k-1];
		end

		// The low half of the operand is zero, so the shifted source runs dry
		// after half the stages.
		assign sh    = {p_rem, p_src[MAG_W-1:MAG_W-2]};
		assign trial = {1'b0, p_root, 2'b01};
		assign ge    = sh >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= p_vld;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k]  <= ge ? RW'(sh - trial) : RW'(sh);
			src_s[k]  <= {p_src[MAG_W-3:0], 2'b00};
			root_s[k] <= {p_root[MAG_W-2:0], ge};
			side_s[k] <= p_side;
		end
	end

	assign out_valid = vld_s[MAG_W-1];
	assign root      = root_s[MAG_W-1];
	assign side_out  = side_s[MAG_W-1];

endmodule

/* design/sdc_axis_lane.sv */
// One axis lane: centre offset, deadzone, per-side scaling and saturation, or bypass.
// Depends on sdc_pkg and sdc_div_pipe.
module sdc_axis_lane import sdc_pkg::*; #(
	parameter int OUT_MIN = DEF_OUT_MIN,
	parameter int OUT_MAX = DEF_OUT_MAX
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic signed [RAW_W-1:0] raw,
	input  axis_cfg_t               cfg,
	output logic                    out_valid,
	output logic signed [RAW_W-1:0] val
);

	localparam logic [15:0] K_POS = 16'(OUT_MAX);
	localparam logic [15:0] K_NEG = 16'(-OUT_MIN);
	localparam int SIDE_W = RAW_W + 3;

	logic signed [17:0] delta;
	logic signed [17:0] dz18;
	logic signed [18:0] span_p;
	logic signed [18:0] span_n;
	logic signed [18:0] span;
	logic signed [17:0] tr;
	logic               inband;
	logic               pos;
	logic               zero;

	assign delta  = 18'(raw) - 18'(cfg.mid);
	assign dz18   = signed'({2'b00, cfg.dz});
	assign inband = (delta <= dz18) && (delta >= -dz18);
	assign pos    = delta > 18'sd0;
	assign span_p = 19'(cfg.hi) - 19'(cfg.mid) - 19'(dz18);
	assign span_n = 19'(cfg.mid) - 19'(cfg.lo) - 19'(dz18);
	assign span   = pos ? span_p : span_n;
	assign tr     = pos ? (delta - dz18) : -(delta + dz18);
	assign zero   = inband || (span <= 19'sd0);

	logic                    vld_s1, vld_s2, vld_s3;
	logic [16:0]             tr_s1;
	logic [16:0]             span_s1, span_s2, span_s3;
	logic                    neg_s1, neg_s2, neg_s3;
	logic                    zero_s1, zero_s2, zero_s3;
	logic signed [RAW_W-1:0] raw_s1, raw_s2, raw_s3;
	logic [32:0]             num_s2, num_s3;
	logic                    sat_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		tr_s1   <= tr[16:0];
		span_s1 <= zero ? 17'd1 : span[16:0];
		neg_s1  <= !pos;
		zero_s1 <= zero;
		raw_s1  <= raw;

		num_s2  <= 33'(tr_s1) * 33'(neg_s1 ? K_NEG : K_POS);
		span_s2 <= span_s1;
		neg_s2  <= neg_s1;
		zero_s2 <= zero_s1;
		raw_s2  <= raw_s1;

		// A quotient of 2^16 or more saturates whatever the limit.
		sat_s3  <= num_s2[32:16] >= span_s2;
		num_s3  <= num_s2;
		span_s3 <= span_s2;
		neg_s3  <= neg_s2;
		zero_s3 <= zero_s2;
		raw_s3  <= raw_s2;
	end

	logic                    d_vld;
	logic [QUO_W-1:0]        d_quo;
	logic [SIDE_W-1:0]       d_side;
	logic signed [RAW_W-1:0] d_raw;
	logic                    d_zero, d_neg, d_sat;
	logic [16:0]             lim;
	logic [16:0]             qmag;
	logic signed [16:0]      sval;

	sdc_div_pipe #(.DW(17), .QW(QUO_W), .SW(SIDE_W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vld_s3),
		.num      (num_s3),
		.den      (span_s3),
		.side_in  ({raw_s3, zero_s3, neg_s3, sat_s3}),
		.out_valid(d_vld),
		.quo      (d_quo),
		.side_out (d_side)
	);

	assign {d_raw, d_zero, d_neg, d_sat} = d_side;
	assign lim  = d_neg ? {1'b0, K_NEG} : {1'b0, K_POS};
	assign qmag = (d_sat || ({1'b0, d_quo} > lim)) ? lim : {1'b0, d_quo};
	assign sval = d_neg ? -signed'(qmag) : signed'(qmag);

	logic                    vld_s4;
	logic signed [RAW_W-1:0] val_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= d_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (cfg.bypass) begin
			val_s4 <= d_raw;
		end else if (d_zero) begin
			val_s4 <= '0;
		end else begin
			val_s4 <= sval[RAW_W-1:0];
		end
	end

	assign out_valid = vld_s4;
	assign val       = val_s4;

endmodule

/* design/sdc_radial.sv */
// Merging stage: radial clamp of the two lane results onto the OUT_MAX circle.
// Depends on sdc_pkg, sdc_isqrt and sdc_div_pipe.
module sdc_radial import sdc_pkg::*; #(
	parameter int OUT_MAX = DEF_OUT_MAX
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic                    enable,
	input  logic signed [RAW_W-1:0] x,
	input  logic signed [RAW_W-1:0] y,
	output logic                    out_valid,
	output logic signed [RAW_W-1:0] ox,
	output logic signed [RAW_W-1:0] oy
);

	localparam logic [MAG_W-1:0] LIM = MAG_W'(OUT_MAX * OUT_MAX);
	localparam logic [14:0]      KM  = 15'(OUT_MAX);
	localparam int DEN_W = MAG_W + 1;
	localparam int NUM_W = QUO_W + DEN_W;
	localparam int SQ_SW = 2 * RAW_W + 1;

	logic                    vld_s1, vld_s2;
	logic [31:0]             xx_s1, yy_s1;
	logic signed [RAW_W-1:0] x_s1, y_s1, x_s2, y_s2;
	logic [MAG_W-1:0]        mag_s2;
	logic                    clamp_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		xx_s1    <= 32'(32'(x) * 32'(x));
		yy_s1    <= 32'(32'(y) * 32'(y));
		x_s1     <= x;
		y_s1     <= y;
		mag_s2   <= xx_s1 + yy_s1;
		clamp_s2 <= enable && ((xx_s1 + yy_s1) > LIM);
		x_s2     <= x_s1;
		y_s2     <= y_s1;
	end

	logic                    q_vld;
	logic [MAG_W-1:0]        q_root;
	logic [SQ_SW-1:0]        q_side;
	logic signed [RAW_W-1:0] q_x, q_y;
	logic                    q_clamp;
	logic [RAW_W-1:0]        ax, ay;

	sdc_isqrt #(.SW(SQ_SW)) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vld_s2),
		.mag      (mag_s2),
		.side_in  ({x_s2, y_s2, clamp_s2}),
		.out_valid(q_vld),
		.root     (q_root),
		.side_out (q_side)
	);

	assign {q_x, q_y, q_clamp} = q_side;
	assign ax = q_x[RAW_W-1] ? RAW_W'(-q_x) : RAW_W'(q_x);
	assign ay = q_y[RAW_W-1] ? RAW_W'(-q_y) : RAW_W'(q_y);

	logic                    vld_s3;
	logic [30:0]             px_s3, py_s3;
	logic [MAG_W-1:0]        r_s3;
	logic signed [RAW_W-1:0] x_s3, y_s3;
	logic                    clamp_s3;
	logic [NUM_W-1:0]        nx, ny;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= q_vld;
		end
	end

	always_ff @(posedge clk) begin
		px_s3    <= 31'(ax) * 31'(KM);
		py_s3    <= 31'(ay) * 31'(KM);
		r_s3     <= q_root;
		x_s3     <= q_x;
		y_s3     <= q_y;
		clamp_s3 <= q_clamp;
	end

	// Rounded quotient (2 * num + r) / (2 * r) with num = |v| * OUT_MAX * 2^16.
	assign nx = NUM_W'({px_s3, 17'd0}) + NUM_W'(r_s3);
	assign ny = NUM_W'({py_s3, 17'd0}) + NUM_W'(r_s3);

	logic                    dx_vld, dy_vld;
	logic [QUO_W-1:0]        dx_q, dy_q;
	logic [RAW_W:0]          dx_side;
	logic [RAW_W-1:0]        dy_side;
	logic signed [RAW_W-1:0] d_x, d_y;
	logic                    d_clamp;

	sdc_div_pipe #(.DW(DEN_W), .QW(QUO_W), .SW(RAW_W + 1)) u_div_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vld_s3),
		.num      (nx),
		.den      ({r_s3, 1'b0}),
		.side_in  ({x_s3, clamp_s3}),
		.out_valid(dx_vld),
		.quo      (dx_q),
		.side_out (dx_side)
	);

	sdc_div_pipe #(.DW(DEN_W), .QW(QUO_W), .SW(RAW_W)) u_div_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vld_s3),
		.num      (ny),
		.den      ({r_s3, 1'b0}),
		.side_in  (y_s3),
		.out_valid(dy_vld),
		.quo      (dy_q),
		.side_out (dy_side)
	);

	assign {d_x, d_clamp} = dx_side;
	assign d_y = signed'(dy_side);

	logic                    vld_s4;
	logic signed [RAW_W-1:0] ox_s4, oy_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= dx_vld && dy_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (d_clamp) begin
			ox_s4 <= d_x[RAW_W-1] ? -signed'(dx_q) : signed'(dx_q);
			oy_s4 <= d_y[RAW_W-1] ? -signed'(dy_q) : signed'(dy_q);
		end else begin
			ox_s4 <= d_x;
			oy_s4 <= d_y;
		end
	end

	assign out_valid = vld_s4;
	assign ox        = ox_s4;
	assign oy        = oy_s4;

endmodule

/* design/stick_deadzone_scale_radial_clamp_unit.sv */
// Top level of the stick calibration block: configuration registers, two axis
// lanes and the radial merging stage. Depends on sdc_pkg, sdc_axis_lane, sdc_radial.
//
// Usage. A raw X/Y word is offered on item with start high; it is taken at any
// rising edge where start is high and busy is low. busy is held low, since the
// block is a full pipeline and takes a new word in every cycle.
// Each result word appears on res with res_valid high for exactly one cycle,
// in order. The pipeline is made of the lane dividers (one quotient bit per
// stage, 16 stages), the root extractor (one root bit per stage, 32 stages)
// and the clamp dividers (16 stages), with stages of offset, multiply and
// selection around them.
// The receiver cannot stall: results are shown once and not held.
// Configuration is written through cfg_we, cfg_addr and cfg_data, one register
// per edge, with no wait; it should only be changed while no word is in flight.
// Register order: X low, X centre, X high, Y low, Y centre, Y high, deadband,
// mode. Reset, which is asynchronous and active low, empties the pipeline and
// loads the registers with a full 16-bit range, a deadband of 600 and bypass.
module stick_deadzone_scale_radial_clamp_unit import sdc_pkg::*; #(
	parameter int OUT_MIN = DEF_OUT_MIN,
	parameter int OUT_MAX = DEF_OUT_MAX
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  in_t              item,
	output logic             res_valid,
	output out_t             res,
	input  logic             cfg_we,
	input  logic [2:0]       cfg_addr,
	input  logic [CFG_W-1:0] cfg_data
);

	// Configuration registers, each taken at its full width.
	logic signed [CFG_W-1:0] x_lo_q, x_mid_q, x_hi_q;
	logic signed [CFG_W-1:0] y_lo_q, y_mid_q, y_hi_q;
	logic [DZ_W-1:0]         dz_q;
	logic [1:0]              mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_lo_q  <= -17'sd32768;
			x_mid_q <= '0;
			x_hi_q  <= 17'sd32767;
			y_lo_q  <= -17'sd32768;
			y_mid_q <= '0;
			y_hi_q  <= 17'sd32767;
			dz_q    <= 16'd600;
			mode_q  <= MODE_BYPASS;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_X_LOW:  x_lo_q  <= signed'(cfg_data);
				REG_X_MID:  x_mid_q <= signed'(cfg_data);
				REG_X_HIGH: x_hi_q  <= signed'(cfg_data);
				REG_Y_LOW:  y_lo_q  <= signed'(cfg_data);
				REG_Y_MID:  y_mid_q <= signed'(cfg_data);
				REG_Y_HIGH: y_hi_q  <= signed'(cfg_data);
				REG_DEAD:   dz_q    <= cfg_data[DZ_W-1:0];
				REG_MODE:   mode_q  <= cfg_data[1:0];
			endcase
		end
	end

	assign busy = 1'b0;

	// Both lanes see the same deadband; bypass passes the raw samples through
	// the lanes so every word takes the same path and latency.
	axis_cfg_t cfg_x, cfg_y;
	logic      accept;

	assign accept = start && !busy;
	assign cfg_x  = '{lo: x_lo_q, mid: x_mid_q, hi: x_hi_q, dz: dz_q,
		bypass: (mode_q == MODE_BYPASS)};
	assign cfg_y  = '{lo: y_lo_q, mid: y_mid_q, hi: y_hi_q, dz: dz_q,
		bypass: (mode_q == MODE_BYPASS)};

	logic                    lx_vld, ly_vld;
	logic signed [RAW_W-1:0] lx, ly;

	sdc_axis_lane #(.OUT_MIN(OUT_MIN), .OUT_MAX(OUT_MAX)) u_lane_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (accept),
		.raw      (item.raw_x),
		.cfg      (cfg_x),
		.out_valid(lx_vld),
		.val      (lx)
	);

	sdc_axis_lane #(.OUT_MIN(OUT_MIN), .OUT_MAX(OUT_MAX)) u_lane_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (accept),
		.raw      (item.raw_y),
		.cfg      (cfg_y),
		.out_valid(ly_vld),
		.val      (ly)
	);

	// The radial clamp applies in the radial mode and in the spare top code,
	// both of which have the upper mode bit set.
	logic                    m_vld;
	logic signed [RAW_W-1:0] mx, my;

	sdc_radial #(.OUT_MAX(OUT_MAX)) u_radial (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (lx_vld && ly_vld),
		.enable   (mode_q[1]),
		.x        (lx),
		.y        (ly),
		.out_valid(m_vld),
		.ox       (mx),
		.oy       (my)
	);

	assign res_valid = m_vld;
	assign res       = '{out_x: mx, out_y: my};

endmodule

/* design/sdc_checker.sv */
// Port-level checker of the stick calibration block and its bind statement.
// Depends on sdc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sdc_checker import sdc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic res_valid
);

	// The pipeline never refuses a word.
	`SDC_ASSERT_NOW(a_never_busy, 1'b1, !busy, "busy raised")

	// Every result traces back to a word that the pipeline took.
	`SDC_ASSERT_NOW(a_result_has_word, res_valid, $past(start && !busy, PIPE_LAT), "result without word")

	// Straight out of reset the pipeline is empty.
	`SDC_ASSERT_NOW(a_empty_after_reset, !$past(arst_n), !res_valid, "result right after reset")

endmodule

bind stick_deadzone_scale_radial_clamp_unit sdc_checker u_sdc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.res_valid(res_valid)
);

/* tb/sv/stick_deadzone_scale_radial_clamp_unit_tb.sv */
// Self-checking testbench of the stick calibration block: directed and random
// stick samples over several register settings. Depends on sdc_pkg and the RTL.
`timescale 1ns / 100ps

module stick_deadzone_scale_radial_clamp_unit_tb;
	import sdc_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int RANDOM_WORDS   = 1850;
	localparam longint CLAMP_MAX  = 32767;
	localparam longint CLAMP_MIN  = -32768;
	// Spare top mode code, which behaves as the radial mode.
	localparam logic [1:0] MODE_TOP = 2'd3;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	in_t              item;
	logic             res_valid;
	out_t             res;
	logic             cfg_we;
	logic [2:0]       cfg_addr;
	logic [CFG_W-1:0] cfg_data;

	stick_deadzone_scale_radial_clamp_unit DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.res_valid(res_valid), .res(res), .cfg_we(cfg_we), .cfg_addr(cfg_addr),
		.cfg_data(cfg_data)
	);

	// The predictor's own copy of the register file.
	longint cal_x_lo, cal_x_mid, cal_x_hi, cal_y_lo, cal_y_mid, cal_y_hi, cal_dead;
	logic [1:0] cal_mode_q;

	in_t  pending_samples[$];
	out_t expected_words[$];
	int   mismatch_count;
	int   words_sent;
	int   words_checked;
	int   idle_cycles;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Sign-extends a 17-bit register value.
	function automatic longint sext17(logic [CFG_W-1:0] v);
		return longint'($signed(v));
	endfunction

	// Deadzone, per-direction span scaling and saturation of one axis.
	function automatic longint calibrate(longint raw, longint lo, longint mid,
		longint hi);
		longint delta, span, val;
		delta = raw - mid;
		if (delta <= cal_dead && delta >= -cal_dead)
			return 0;
		if (delta > 0) begin
			span = hi - mid - cal_dead;
			if (span <= 0)
				return 0;
			val = (delta - cal_dead) * CLAMP_MAX / span;
			return (val > CLAMP_MAX) ? CLAMP_MAX : val;
		end
		span = mid - lo - cal_dead;
		if (span <= 0)
			return 0;
		val = (delta + cal_dead) * (-CLAMP_MIN) / span;
		return (val < CLAMP_MIN) ? CLAMP_MIN : val;
	endfunction

	// Floor square root by the bit-pair method.
	function automatic logic [63:0] floor_root(logic [63:0] v);
		logic [63:0] acc, bit_q;
		acc = 0;
		bit_q = 64'd1 << 62;
		while (bit_q > v)
			bit_q = bit_q >> 2;
		while (bit_q != 0) begin
			if (v >= acc + bit_q) begin
				v = v - (acc + bit_q);
				acc = (acc >> 1) + bit_q;
			end else begin
				acc = acc >> 1;
			end
			bit_q = bit_q >> 2;
		end
		return acc;
	endfunction

	// Rescales one axis onto the clamp circle, rounding half away from zero.
	function automatic longint onto_circle(longint a, logic [63:0] root);
		logic [63:0] mag, num, q;
		mag = (a < 0) ? -a : a;
		num = mag * CLAMP_MAX * 64'd65536;
		q = (2 * num + root) / (2 * root);
		return (a < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic out_t predict_word(in_t s);
		longint x, y;
		logic [63:0] mag;
		logic [63:0] root;
		out_t o;
		if (cal_mode_q == MODE_BYPASS) begin
			x = s.raw_x;
			y = s.raw_y;
		end else begin
			x = calibrate(longint'(s.raw_x), cal_x_lo, cal_x_mid, cal_x_hi);
			y = calibrate(longint'(s.raw_y), cal_y_lo, cal_y_mid, cal_y_hi);
			// Both the radial mode and the top mode code apply the clamp.
			if (cal_mode_q[1]) begin
				mag = x * x + y * y;
				if (mag > CLAMP_MAX * CLAMP_MAX) begin
					root = floor_root(mag << 32);
					x = onto_circle(x, root);
					y = onto_circle(y, root);
				end
			end
		end
		o.out_x = x[15:0];
		o.out_y = y[15:0];
		return o;
	endfunction

	// Driver: takes one sample from the queue per accepted word, with random gaps.
	int gap_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			item <= '0;
			gap_left <= 0;
		end else begin
			if (start && !busy) begin
				expected_words.push_back(predict_word(item));
				words_sent <= words_sent + 1;
			end
			if (start && busy) begin
				// Still waiting for the current word to be taken.
			end else if (gap_left > 0) begin
				start <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pending_samples.size() > 0) begin
				start <= 1'b1;
				item <= pending_samples.pop_front();
				// Mostly back to back, sometimes short pauses, rarely long ones.
				case ($urandom_range(0, 19))
					0, 1, 2, 3: gap_left <= $urandom_range(1, 3);
					4: gap_left <= $urandom_range(10, 40);
					default: gap_left <= 0;
				endcase
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: compares each result word with the oldest expectation.
	always @(posedge clk) begin
		out_t want;
		if (arst_n && res_valid) begin
			words_checked <= words_checked + 1;
			if (expected_words.size() == 0) begin
				mismatch_count = mismatch_count + 1;
				if (mismatch_count <= 10)
					$display("unexpected result word x=%0d y=%0d", res.out_x, res.out_y);
			end else begin
				want = expected_words.pop_front();
				if (res.out_x !== want.out_x || res.out_y !== want.out_y) begin
					mismatch_count = mismatch_count + 1;
					if (mismatch_count <= 10)
						$display("mismatch: expected x=%0d y=%0d, got x=%0d y=%0d",
							want.out_x, want.out_y, res.out_x, res.out_y);
				end
			end
		end
	end

	// Watchdog on cycles where nothing is taken in or delivered.
	always @(posedge clk) begin
		if ((start && !busy) || res_valid)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("stick_deadzone_scale_radial_clamp_unit test failed");
			$finish;
		end
	end

	task automatic write_reg(logic [2:0] idx, longint value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= value[CFG_W-1:0];
		case (idx)
			REG_X_LOW:  cal_x_lo = sext17(value[CFG_W-1:0]);
			REG_X_MID:  cal_x_mid = sext17(value[CFG_W-1:0]);
			REG_X_HIGH: cal_x_hi = sext17(value[CFG_W-1:0]);
			REG_Y_LOW:  cal_y_lo = sext17(value[CFG_W-1:0]);
			REG_Y_MID:  cal_y_mid = sext17(value[CFG_W-1:0]);
			REG_Y_HIGH: cal_y_hi = sext17(value[CFG_W-1:0]);
			REG_DEAD:   cal_dead = value & 64'hFFFF;
			default:    cal_mode_q = value[1:0];
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic load_setting(longint xl, longint xm, longint xh, longint yl,
		longint ym, longint yh, longint dz, logic [1:0] mode);
		write_reg(REG_X_LOW, xl);
		write_reg(REG_X_MID, xm);
		write_reg(REG_X_HIGH, xh);
		write_reg(REG_Y_LOW, yl);
		write_reg(REG_Y_MID, ym);
		write_reg(REG_Y_HIGH, yh);
		write_reg(REG_DEAD, dz);
		write_reg(REG_MODE, mode);
	endtask

	// Waits until every word is in and answered, then lets the pipeline drain.
	task automatic drain;
		while (pending_samples.size() > 0 || start || expected_words.size() > 0)
			@(posedge clk);
		repeat (PIPE_LAT + 8) @(posedge clk);
	endtask

	task automatic queue_sample(longint x, longint y);
		in_t s;
		s.raw_x = x[15:0];
		s.raw_y = y[15:0];
		pending_samples.push_back(s);
	endtask

	// Random samples biased towards the band around the centre and the rails.
	function automatic longint pick_raw(longint mid);
		case ($urandom_range(0, 5))
			0: return mid + longint'($urandom_range(0, 2 * 1300)) - 1300;
			1: return ($urandom_range(0, 1)) ? 32767 : -32768;
			default: return longint'($signed(16'($urandom())));
		endcase
	endfunction

	task automatic random_phase(int count);
		repeat (count)
			queue_sample(pick_raw(cal_x_mid), pick_raw(cal_y_mid));
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = REG_X_LOW;
		cfg_data = '0;
		mismatch_count = 0;
		words_sent = 0;
		words_checked = 0;
		idle_cycles = 0;
		cal_x_lo = -32768; cal_x_mid = 0; cal_x_hi = 32767;
		cal_y_lo = -32768; cal_y_mid = 0; cal_y_hi = 32767;
		cal_dead = 600;
		cal_mode_q = MODE_BYPASS;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: reset settings in bypass, then the rails in each mode.
		queue_sample(32767, -32768);
		queue_sample(-1, 0);
		drain();
		for (int m = MODE_CAL; m <= MODE_TOP; m++) begin
			write_reg(REG_MODE, m);
			queue_sample(0, 0);
			queue_sample(600, -600);   // on the band edge
			queue_sample(601, -601);   // just past it
			queue_sample(32767, 32767); // diagonal, clamped in radial mode
			queue_sample(-32768, -32768);
			queue_sample(32767, -32768);
			drain();
		end
		// Spans that are zero or negative on each side.
		load_setting(100, 100, 100, 40000, -40000, -40000, 0, MODE_RADIAL);
		queue_sample(-32768, 32767);
		queue_sample(32767, -32768);
		queue_sample(100, -40);
		drain();
		// Largest deadband, which swallows every sample, over a narrow Y span.
		load_setting(-131072, 0, 131071, -10, 0, 10, 65535, MODE_CAL);
		queue_sample(32767, 32767);
		queue_sample(-32768, -32768);
		drain();

		// Random phases over several settings, extremes included.
		for (int p = 0; p < 8; p++) begin
			case (p)
				0: load_setting(-32768, 0, 32767, -32768, 0, 32767, 600, MODE_RADIAL);
				1: load_setting(-40000, 0, 40000, -20000, 500, 9000, 0, MODE_CAL);
				2: load_setting(-30000, -2000, 31000, -32000, 1500, 28000, 2000, MODE_TOP);
				3: load_setting(-100, 0, 100, -300, 0, 200, 5, MODE_RADIAL);
				4: load_setting(40000, 0, -40000, 0, 0, 0, 65535, MODE_RADIAL);
				5: load_setting(-40000, 40000, -40000, -40000, -40000, 40000, 300, MODE_TOP);
				6: load_setting(-32768, 0, 32767, -32768, 0, 32767, 0, MODE_BYPASS);
				default: load_setting(
					-longint'($urandom_range(0, 40000)), longint'($urandom_range(0, 4000)) - 2000,
					longint'($urandom_range(0, 40000)), -longint'($urandom_range(0, 40000)),
					longint'($urandom_range(0, 4000)) - 2000, longint'($urandom_range(0, 40000)),
					$urandom_range(0, 3000), 2'($urandom_range(1, 3)));
			endcase
			random_phase(RANDOM_WORDS / 8);
			drain();
		end

		$display("%0d words sent, %0d results checked over bypass, per-axis and radial settings",
			words_sent, words_checked);
		if (mismatch_count == 0)
			$display("stick_deadzone_scale_radial_clamp_unit test passed");
		else
			$display("stick_deadzone_scale_radial_clamp_unit test failed");
		$finish;
	end

endmodule

/* sim.f */
+incdir+design
design/sdc_pkg.sv
design/sdc_div_pipe.sv
design/sdc_isqrt.sv
design/sdc_axis_lane.sv
design/sdc_radial.sv
design/stick_deadzone_scale_radial_clamp_unit.sv
design/sdc_checker.sv
tb/sv/stick_deadzone_scale_radial_clamp_unit_tb.sv
